// File: rtl/core/pcch_pkg.sv
package pcch_pkg;

  localparam int HISTORY_DEPTH = 20;
  localparam int AVG_CYCLES    = 2;
  localparam int AVG_POS       = 2 * AVG_CYCLES - 1;
  localparam int DATA_W        = 32;
  localparam int KIND_W        = 4;
  localparam int IDX_W         = 5;
  localparam int CNT_W         = $clog2(HISTORY_DEPTH + 1);
  localparam int PTR_W         = $clog2(HISTORY_DEPTH);
  localparam int CFG_IDX_W     = 1;

  localparam logic [DATA_W-1:0] WINDOW_RESET = 32'd5000;

  localparam logic [CFG_IDX_W-1:0] REG_MODE   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW = 1'd1;

  localparam logic [KIND_W-1:0] KIND_PULSE     = 4'd0;
  localparam logic [KIND_W-1:0] KIND_DECREMENT = 4'd1;
  localparam logic [KIND_W-1:0] KIND_DELETE    = 4'd2;
  localparam logic [KIND_W-1:0] KIND_PERIOD    = 4'd3;
  localparam logic [KIND_W-1:0] KIND_SET_USAGE = 4'd4;
  localparam logic [KIND_W-1:0] KIND_CLEAR     = 4'd5;
  localparam logic [KIND_W-1:0] KIND_CLEAR_HIST = 4'd6;
  localparam logic [KIND_W-1:0] KIND_READ_STAMP = 4'd7;
  localparam logic [KIND_W-1:0] KIND_READ_LONG  = 4'd8;

  typedef enum logic [1:0] {
    SEL_AVG,
    SEL_IDX,
    SEL_SCAN,
    SEL_SCAN_NEXT
  } rd_sel_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_SIMPLE,
    OP_AVG_UPD,
    OP_PULSE_WR,
    OP_STAMP_CAP,
    OP_LONG_CAP,
    OP_SCAN_STEP,
    OP_DEL_APPLY,
    OP_OUT_LOAD
  } op_t;

  typedef struct packed {
    logic    load;
    logic    rd_en;
    rd_sel_t rd_sel;
    op_t     op;
  } cmd_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              mode;
    logic              fill_gt_avg;
    logic              idx_in;
    logic              fill_nz;
    logic              longest_nz;
    logic              scan_hit;
    logic              scan_more;
    logic              out_free;
  } status_t;

endpackage

// File: rtl/core/pcch_if.sv
interface pcch_in_if;
  logic        valid;
  logic        ready;
  logic [3:0]  kind;
  logic [31:0] now_ms;
  logic [31:0] amount;
  logic        flag;
  logic [4:0]  index;

  modport source (output valid, kind, now_ms, amount, flag, index, input ready);
  modport sink   (input valid, kind, now_ms, amount, flag, index, output ready);
endinterface

interface pcch_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] half_cycles;
  logic [4:0]  stamps_filled;
  logic [31:0] stamp_value;
  logic        longest_valid;
  logic [31:0] longest_ms;
  logic [4:0]  deleted;

  modport source (output valid, half_cycles, stamps_filled, stamp_value, longest_valid,
                  longest_ms, deleted, input ready);
  modport sink   (input valid, half_cycles, stamps_filled, stamp_value, longest_valid,
                  longest_ms, deleted, output ready);
endinterface

// File: rtl/core/pcch_ctrl.sv
module pcch_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  pcch_pkg::status_t st,
  output pcch_pkg::cmd_t    cmd
);
  import pcch_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DECODE = 4'd1;
  localparam logic [3:0] S_AVG    = 4'd2;
  localparam logic [3:0] S_PULSE  = 4'd3;
  localparam logic [3:0] S_STAMP  = 4'd4;
  localparam logic [3:0] S_LONG   = 4'd5;
  localparam logic [3:0] S_SCAN   = 4'd6;
  localparam logic [3:0] S_DEL    = 4'd7;
  localparam logic [3:0] S_DONE   = 4'd8;

  logic [3:0] state;
  logic [3:0] state_next;

  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd.load   = 1'b0;
    cmd.rd_en  = 1'b0;
    cmd.rd_sel = SEL_AVG;
    cmd.op     = OP_NONE;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        state_next = S_DONE;
        unique case (st.kind)
          KIND_PULSE: begin
            if (!st.mode) begin
              if (st.fill_gt_avg) begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = SEL_AVG;
                state_next = S_AVG;
              end else begin
                state_next = S_PULSE;
              end
            end
          end
          KIND_DELETE: begin
            if (!st.mode && st.fill_nz) begin
              cmd.rd_en  = 1'b1;
              cmd.rd_sel = SEL_SCAN;
              state_next = S_SCAN;
            end
          end
          KIND_READ_STAMP: begin
            if (st.idx_in) begin
              cmd.rd_en  = 1'b1;
              cmd.rd_sel = SEL_IDX;
              state_next = S_STAMP;
            end
          end
          KIND_READ_LONG: begin
            if (!st.mode && st.longest_nz) begin
              if (st.fill_gt_avg) begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = SEL_AVG;
                state_next = S_LONG;
              end else begin
                cmd.op = OP_LONG_CAP;
              end
            end
          end
          default: cmd.op = OP_SIMPLE;
        endcase
      end
      S_AVG: begin
        cmd.op     = OP_AVG_UPD;
        state_next = S_PULSE;
      end
      S_PULSE: begin
        cmd.op     = OP_PULSE_WR;
        state_next = S_DONE;
      end
      S_STAMP: begin
        cmd.op     = OP_STAMP_CAP;
        state_next = S_DONE;
      end
      S_LONG: begin
        cmd.op     = OP_LONG_CAP;
        state_next = S_DONE;
      end
      S_SCAN: begin
        cmd.op = OP_SCAN_STEP;
        if (st.scan_hit && st.scan_more) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = SEL_SCAN_NEXT;
        end else begin
          state_next = S_DEL;
        end
      end
      S_DEL: begin
        cmd.op     = OP_DEL_APPLY;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (st.out_free) begin
          cmd.op     = OP_OUT_LOAD;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// File: rtl/core/pcch_dp.sv
module pcch_dp (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [pcch_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [pcch_pkg::DATA_W-1:0]      cfg_data,
  input  logic [pcch_pkg::KIND_W-1:0]      in_kind,
  input  logic [pcch_pkg::DATA_W-1:0]      in_now_ms,
  input  logic [pcch_pkg::DATA_W-1:0]      in_amount,
  input  logic                             in_flag,
  input  logic [pcch_pkg::IDX_W-1:0]       in_index,
  input  pcch_pkg::cmd_t                   cmd,
  output pcch_pkg::status_t                st,
  input  logic                             out_ready,
  output logic                             out_valid,
  output logic [pcch_pkg::DATA_W-1:0]      out_half_cycles,
  output logic [pcch_pkg::IDX_W-1:0]       out_stamps_filled,
  output logic [pcch_pkg::DATA_W-1:0]      out_stamp_value,
  output logic                             out_longest_valid,
  output logic [pcch_pkg::DATA_W-1:0]      out_longest_ms,
  output logic [pcch_pkg::IDX_W-1:0]       out_deleted
);
  import pcch_pkg::*;

  localparam int SUM_W = CNT_W + 1;
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(HISTORY_DEPTH - 1);
  localparam logic [CNT_W-1:0] DEPTH_C  = CNT_W'(HISTORY_DEPTH);

  // newest stamp sits at head, older ones at increasing offsets (mod depth)
  logic [DATA_W-1:0] mem [HISTORY_DEPTH];

  logic [KIND_W-1:0] kind;
  logic [DATA_W-1:0] now_ms;
  logic [DATA_W-1:0] amount;
  logic              flag;
  logic [IDX_W-1:0]  idx;
  logic              mode;
  logic [DATA_W-1:0] window;
  logic [DATA_W-1:0] count;
  logic [CNT_W-1:0]  fill;
  logic [PTR_W-1:0]  head;
  logic [DATA_W-1:0] longest;
  logic [CNT_W-1:0]  scan_n;
  logic [DATA_W-1:0] rdata;
  logic [DATA_W-1:0] res_stamp;
  logic              res_lvalid;
  logic [DATA_W-1:0] res_lms;
  logic [CNT_W-1:0]  res_del;

  logic [CNT_W-1:0]  offset;
  logic [PTR_W-1:0]  rd_addr;
  logic [PTR_W-1:0]  head_dec;
  logic [DATA_W-1:0] avg_old;
  logic [DATA_W-1:0] avg;
  logic [DATA_W-1:0] scan_age;
  logic [DATA_W-1:0] n_ext;

  function automatic logic [PTR_W-1:0] wrap_add(logic [PTR_W-1:0] base,
                                                logic [CNT_W-1:0] off);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(base) + SUM_W'(off);
    if (sum >= SUM_W'(HISTORY_DEPTH)) begin
      sum = sum - SUM_W'(HISTORY_DEPTH);
    end
    return sum[PTR_W-1:0];
  endfunction

  always_comb begin
    case (cmd.rd_sel)
      SEL_AVG:       offset = CNT_W'(AVG_POS);
      SEL_IDX:       offset = idx[CNT_W-1:0];
      SEL_SCAN:      offset = scan_n;
      SEL_SCAN_NEXT: offset = scan_n + CNT_W'(1);
      default:       offset = '0;
    endcase
  end

  assign rd_addr  = wrap_add(head, offset);
  assign head_dec = (head == '0) ? LAST_PTR : head - PTR_W'(1);
  // a stamp past the fill reads as zero
  assign avg_old  = st.fill_gt_avg ? rdata : '0;
  assign avg      = (now_ms - avg_old) / AVG_CYCLES;
  assign scan_age = now_ms - rdata;
  assign n_ext    = DATA_W'(scan_n);

  assign st.kind        = kind;
  assign st.mode        = mode;
  assign st.fill_gt_avg = (SUM_W'(fill) > SUM_W'(AVG_POS));
  assign st.idx_in      = (SUM_W'(idx) < SUM_W'(fill));
  assign st.fill_nz     = (fill != '0);
  assign st.longest_nz  = (longest != '0);
  assign st.scan_hit    = (scan_age < window);
  assign st.scan_more   = (SUM_W'(scan_n) + SUM_W'(1) < SUM_W'(fill));
  assign st.out_free    = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rdata <= mem[rd_addr];
    end
    if (cmd.op == OP_PULSE_WR) begin
      mem[head_dec] <= now_ms;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind       <= in_kind;
      now_ms     <= in_now_ms;
      amount     <= in_amount;
      flag       <= in_flag;
      idx        <= in_index;
      scan_n     <= '0;
      res_stamp  <= '0;
      res_lvalid <= 1'b0;
      res_lms    <= '0;
      res_del    <= '0;
    end
    case (cmd.op)
      OP_STAMP_CAP: res_stamp <= rdata;
      OP_LONG_CAP: begin
        res_lvalid <= 1'b1;
        res_lms    <= (avg > longest) ? avg : longest;
      end
      OP_SCAN_STEP: begin
        if (st.scan_hit) begin
          scan_n <= scan_n + CNT_W'(1);
        end
      end
      OP_DEL_APPLY: res_del <= scan_n;
      OP_OUT_LOAD: begin
        out_half_cycles   <= count;
        out_stamps_filled <= IDX_W'(fill);
        out_stamp_value   <= res_stamp;
        out_longest_valid <= res_lvalid;
        out_longest_ms    <= res_lms;
        out_deleted       <= IDX_W'(res_del);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= 1'b0;
      window    <= WINDOW_RESET;
      count     <= '0;
      fill      <= '0;
      head      <= '0;
      longest   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_MODE:   mode   <= cfg_data[0];
          REG_WINDOW: window <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.op == OP_OUT_LOAD) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (cmd.op)
        OP_SIMPLE: begin
          case (kind)
            KIND_DECREMENT: count <= (amount > count) ? '0 : count - amount;
            KIND_PERIOD: begin
              if (!mode) begin
                longest <= '0;
              end
            end
            KIND_SET_USAGE: begin
              if (mode) begin
                count <= {amount[DATA_W-2:0], 1'b0};
              end
            end
            KIND_CLEAR: begin
              if (flag) begin
                count <= '0;
              end
              longest <= '0;
              fill    <= '0;
            end
            KIND_CLEAR_HIST: fill <= '0;
            default: ;
          endcase
        end
        OP_AVG_UPD: begin
          if (avg > longest) begin
            longest <= avg;
          end
        end
        OP_PULSE_WR: begin
          count <= count + DATA_W'(flag);
          head  <= head_dec;
          if (fill < DEPTH_C) begin
            fill <= fill + CNT_W'(1);
          end
        end
        OP_DEL_APPLY: begin
          head  <= wrap_add(head, scan_n);
          fill  <= fill - scan_n;
          count <= (n_ext > count) ? '0 : count - n_ext;
        end
        default: ;
      endcase
    end
  end

endmodule

// File: rtl/core/pulse_cycle_counter_with_history.sv
// One item in flight: a new item is taken only once the last result is loaded
// into the output. A pulse takes an extra averaging step with four or more
// stamps held, and a delete scans the held stamps one by one before it applies.
// The result waits in the done state until the output is free; the pace is set
// by the single history read port and the stamp-by-stamp delete scan.
// Reset (rst, synchronous, high) clears count, fill, longest and config.
module pulse_cycle_counter_with_history (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [pcch_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pcch_pkg::DATA_W-1:0]    cfg_data,
  pcch_in_if.sink                        in_ch,
  pcch_out_if.source                     out_ch
);
  import pcch_pkg::*;

  cmd_t    cmd;
  status_t st;

  pcch_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .st       (st),
    .cmd      (cmd)
  );

  pcch_dp u_dp (
    .clk               (clk),
    .rst               (rst),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_kind           (in_ch.kind),
    .in_now_ms         (in_ch.now_ms),
    .in_amount         (in_ch.amount),
    .in_flag           (in_ch.flag),
    .in_index          (in_ch.index),
    .cmd               (cmd),
    .st                (st),
    .out_ready         (out_ch.ready),
    .out_valid         (out_ch.valid),
    .out_half_cycles   (out_ch.half_cycles),
    .out_stamps_filled (out_ch.stamps_filled),
    .out_stamp_value   (out_ch.stamp_value),
    .out_longest_valid (out_ch.longest_valid),
    .out_longest_ms    (out_ch.longest_ms),
    .out_deleted       (out_ch.deleted)
  );

endmodule

// File: rtl/core/pcch_checker.sv
module pcch_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [4:0]  stamps_filled,
  input logic [31:0] stamp_value,
  input logic        longest_valid,
  input logic [31:0] longest_ms,
  input logic [4:0]  deleted
);
  import pcch_pkg::*;

  // one item at a time: a beat in closes the input for the next cycle
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted twice in a row");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_fill_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (stamps_filled <= IDX_W'(HISTORY_DEPTH)) &&
                  (deleted <= IDX_W'(HISTORY_DEPTH)))
    else $error("fill or delete count beyond history depth");

  a_longest_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !longest_valid |-> longest_ms == '0)
    else $error("longest value without valid");

  // a delete beat carries no read results
  a_delete_exclusive: assert property (@(posedge clk) disable iff (rst)
    out_valid && deleted != '0 |-> stamp_value == '0 && !longest_valid)
    else $error("delete beat mixed with read results");

endmodule

bind pulse_cycle_counter_with_history pcch_checker u_pcch_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .stamps_filled (out_ch.stamps_filled),
  .stamp_value   (out_ch.stamp_value),
  .longest_valid (out_ch.longest_valid),
  .longest_ms    (out_ch.longest_ms),
  .deleted       (out_ch.deleted)
);

// File: sim/meter_event_checker.sv
module meter_event_checker
  import pcch_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DATA_W-1:0]    cfg_data,
  pcch_in_if                   in_ch,
  pcch_out_if                  out_ch,
  output int unsigned          fail_count,
  output int unsigned          results_seen,
  output int unsigned          waiting
);

  localparam int unsigned PRINT_CAP = 100;

  typedef struct packed {
    logic [DATA_W-1:0] half_cycles;
    logic [4:0]        stamps_filled;
    logic [DATA_W-1:0] stamp_value;
    logic              longest_valid;
    logic [DATA_W-1:0] longest_ms;
    logic [4:0]        deleted;
  } readout_t;

  // shadow of the meter state
  logic              mode_q;
  logic [DATA_W-1:0] window_q;
  logic [DATA_W-1:0] count_q;
  logic [DATA_W-1:0] longest_q;
  logic [DATA_W-1:0] stamps [HISTORY_DEPTH];
  int unsigned       fill_q;

  readout_t expected_readouts[$];
  readout_t want;

  task automatic report(input string what);
    fail_count++;
    if (fail_count <= PRINT_CAP) $display("MISMATCH: %s", what);
  endtask

  // entries past the fill count read as zero
  function automatic logic [DATA_W-1:0] stamp_or_zero(input int unsigned pos);
    return (pos < fill_q && pos < HISTORY_DEPTH) ? stamps[pos] : '0;
  endfunction

  function automatic logic [DATA_W-1:0] spacing_at(input logic [DATA_W-1:0] now);
    logic [DATA_W-1:0] span;
    span = now - stamp_or_zero(AVG_POS);
    return span / AVG_CYCLES;
  endfunction

  task automatic apply_event(input logic [KIND_W-1:0] kind, input logic [DATA_W-1:0] now,
                             input logic [DATA_W-1:0] amount, input logic flag,
                             input logic [IDX_W-1:0] idx, output readout_t r);
    int unsigned       n;
    int unsigned       top;
    logic [DATA_W-1:0] avg;
    r = '0;
    case (kind)
      KIND_PULSE: if (!mode_q) begin
        if (flag) count_q = count_q + 1;
        if (fill_q > 0) begin
          if (fill_q > AVG_POS) begin
            avg = spacing_at(now);
            if (avg > longest_q) longest_q = avg;
          end
          top = (fill_q < HISTORY_DEPTH - 1) ? fill_q : HISTORY_DEPTH - 1;
          for (int i = top; i > 0; i--) stamps[i] = stamps[i-1];
        end
        stamps[0] = now;
        if (fill_q < HISTORY_DEPTH) fill_q++;
      end
      KIND_DECREMENT: begin
        count_q = (amount > count_q) ? '0 : count_q - amount;
      end
      KIND_DELETE: if (!mode_q) begin
        n = 0;
        // scan stops at the first stamp that is not recent
        while (n < fill_q && n < HISTORY_DEPTH && (now - stamps[n]) < window_q) n++;
        if (n > 0) begin
          for (int i = 0; i < HISTORY_DEPTH; i++)
            stamps[i] = (i + n < HISTORY_DEPTH) ? stamps[i + n] : '0;
          count_q = (n > count_q) ? '0 : count_q - n;
          fill_q = fill_q - n;
        end
        r.deleted = 5'(n);
      end
      KIND_PERIOD: begin
        if (!mode_q) longest_q = '0;
      end
      KIND_SET_USAGE: begin
        if (mode_q) count_q = amount * 2;
      end
      KIND_CLEAR: begin
        if (flag) count_q = '0;
        longest_q = '0;
        fill_q = 0;
        foreach (stamps[i]) stamps[i] = '0;
      end
      KIND_CLEAR_HIST: begin
        fill_q = 0;
      end
      KIND_READ_STAMP: begin
        r.stamp_value = stamp_or_zero(idx);
      end
      KIND_READ_LONG: if (!mode_q && longest_q != 0) begin
        avg = spacing_at(now);
        r.longest_valid = 1'b1;
        r.longest_ms = (avg > longest_q) ? avg : longest_q;
      end
      default: ;
    endcase
    r.half_cycles = count_q;
    r.stamps_filled = 5'(fill_q);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      mode_q = 1'b0;
      window_q = WINDOW_RESET;
      count_q = '0;
      longest_q = '0;
      fill_q = 0;
      foreach (stamps[i]) stamps[i] = '0;
      expected_readouts.delete();
      fail_count = 0;
      results_seen <= 0;
      waiting <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_MODE:   mode_q = cfg_data[0];
          REG_WINDOW: window_q = cfg_data;
          default: ;
        endcase
      end
      // compare before pushing so a beat never matches its own event
      if (out_ch.valid && out_ch.ready) begin
        results_seen <= results_seen + 1;
        if (expected_readouts.size() == 0) begin
          report($sformatf("result %0d arrived with nothing expected", results_seen));
        end else begin
          want = expected_readouts.pop_front();
          if (out_ch.half_cycles !== want.half_cycles)
            report($sformatf("result %0d half_cycles %0h, expected %0h", results_seen,
                             out_ch.half_cycles, want.half_cycles));
          if (out_ch.stamps_filled !== want.stamps_filled)
            report($sformatf("result %0d stamps_filled %0d, expected %0d", results_seen,
                             out_ch.stamps_filled, want.stamps_filled));
          if (out_ch.stamp_value !== want.stamp_value)
            report($sformatf("result %0d stamp_value %0h, expected %0h", results_seen,
                             out_ch.stamp_value, want.stamp_value));
          if (out_ch.longest_valid !== want.longest_valid)
            report($sformatf("result %0d longest_valid %0b, expected %0b", results_seen,
                             out_ch.longest_valid, want.longest_valid));
          if (out_ch.longest_ms !== want.longest_ms)
            report($sformatf("result %0d longest_ms %0h, expected %0h", results_seen,
                             out_ch.longest_ms, want.longest_ms));
          if (out_ch.deleted !== want.deleted)
            report($sformatf("result %0d deleted %0d, expected %0d", results_seen,
                             out_ch.deleted, want.deleted));
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        apply_event(in_ch.kind, in_ch.now_ms, in_ch.amount, in_ch.flag, in_ch.index, want);
        expected_readouts.push_back(want);
      end
      waiting <= expected_readouts.size();
    end
  end

endmodule

// File: sim/testbench.sv
module testbench;
  import pcch_pkg::*;

  localparam int unsigned CYCLE_LIMIT     = 600000;
  localparam int unsigned EVENTS_PER_PASS = 190;
  localparam int unsigned PASSES          = 8;
  localparam int unsigned HOLD_CYCLES     = 300;
  localparam int unsigned DRAIN_CYCLES    = 30;
  localparam int unsigned IDLE_PCT        = 34;

  localparam logic [KIND_W-1:0] KIND_FIRST_UNUSED = 4'd9;
  localparam logic [KIND_W-1:0] KIND_LAST_UNUSED  = 4'd15;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [DATA_W-1:0]    cfg_data = '0;

  pcch_in_if  in_ch();
  pcch_out_if out_ch();

  int unsigned fail_count;
  int unsigned results_seen;
  int unsigned waiting;

  int unsigned       sent = 0;
  int unsigned       directed_sent = 0;
  int unsigned       cycles = 0;
  int unsigned       hold_left = 0;
  logic              hold_go = 1'b0;
  logic              hold_seen = 1'b0;
  logic              burst = 1'b0;
  logic [DATA_W-1:0] wall_ms = 32'hFFFF_0000;

  pulse_cycle_counter_with_history dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  meter_event_checker u_meter_check (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_ch        (in_ch),
    .out_ch       (out_ch),
    .fail_count   (fail_count),
    .results_seen (results_seen),
    .waiting      (waiting)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results of %0d", cycles, results_seen, sent);
      $display("TEST FAILED");
      $finish;
    end
  end

  // result side: random back-pressure, plus one long hold on request
  always @(posedge clk) begin
    if (hold_seen != hold_go) begin
      hold_seen <= hold_go;
      hold_left <= HOLD_CYCLES;
      out_ch.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= burst || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  task automatic send_event(input logic [KIND_W-1:0] kind, input logic [DATA_W-1:0] now,
                            input logic [DATA_W-1:0] amount, input logic flag,
                            input logic [IDX_W-1:0] idx);
    while (!burst && $urandom_range(99) < IDLE_PCT) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.kind <= kind;
    in_ch.now_ms <= now;
    in_ch.amount <= amount;
    in_ch.flag <= flag;
    in_ch.index <= idx;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sent++;
  endtask

  // must follow an accepted beat: valid goes low once, then wait for every result
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (results_seen != sent) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic random_event();
    int unsigned       pick;
    logic [DATA_W-1:0] now;
    logic [DATA_W-1:0] amount;
    pick = $urandom_range(199);
    case ($urandom_range(19))
      0: ;
      1: wall_ms += $urandom;
      2, 3: wall_ms += $urandom_range(40000, 5000);
      default: wall_ms += $urandom_range(2500, 1);
    endcase
    // a few events carry a time unrelated to the running clock
    now = ($urandom_range(24) == 0) ? $urandom : wall_ms;
    amount = $urandom;
    if (pick < 92)
      send_event(KIND_PULSE, now, amount, $urandom_range(9) != 0, 5'($urandom));
    else if (pick < 112)
      send_event(KIND_READ_STAMP, now, amount, 1'($urandom), 5'($urandom));
    else if (pick < 132)
      send_event(KIND_READ_LONG, now, amount, 1'($urandom), 5'($urandom));
    else if (pick < 146)
      send_event(KIND_DELETE, now, amount, 1'($urandom), 5'($urandom));
    else if (pick < 158) begin
      if ($urandom_range(3) != 0) amount = $urandom_range(8);
      send_event(KIND_DECREMENT, now, amount, 1'($urandom), 5'($urandom));
    end else if (pick < 166)
      send_event(KIND_PERIOD, now, amount, 1'($urandom), 5'($urandom));
    else if (pick < 178)
      send_event(KIND_SET_USAGE, now, amount, 1'($urandom), 5'($urandom));
    else if (pick < 181)
      send_event(KIND_CLEAR, now, amount, 1'($urandom), 5'($urandom));
    else if (pick < 184)
      send_event(KIND_CLEAR_HIST, now, amount, 1'($urandom), 5'($urandom));
    else if (pick < 190)
      send_event(KIND_W'($urandom_range(KIND_LAST_UNUSED, KIND_FIRST_UNUSED)), now, amount,
                 1'($urandom), 5'($urandom));
    else
      send_event(KIND_PULSE, wall_ms, amount, 1'b1, 5'($urandom));
  endtask

  initial begin
    logic [DATA_W-1:0] base;
    logic              pass_mode;
    logic [DATA_W-1:0] pass_window;
    in_ch.valid = 1'b0;
    in_ch.kind = KIND_PULSE;
    in_ch.now_ms = '0;
    in_ch.amount = '0;
    in_ch.flag = 1'b0;
    in_ch.index = '0;
    out_ch.ready = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed events, pulse mode, default window
    base = 32'hFFFF_E000;
    send_event(KIND_READ_STAMP, base, '0, 1'b0, '0);
    send_event(KIND_READ_LONG, base, '0, 1'b0, '0);
    send_event(KIND_LAST_UNUSED, '1, '1, 1'b1, '1);
    send_event(KIND_DECREMENT, base, 32'd5, 1'b0, '0);
    send_event(KIND_SET_USAGE, base, 32'd7, 1'b0, '0);
    // five pulses across the 32-bit wrap; the fifth updates the longest spacing
    send_event(KIND_PULSE, base, '0, 1'b1, '0);
    send_event(KIND_PULSE, base + 3000, '0, 1'b1, '0);
    send_event(KIND_PULSE, base + 6000, '0, 1'b0, '0);
    send_event(KIND_PULSE, base + 9000, '0, 1'b1, '0);
    send_event(KIND_PULSE, base + 12000, '0, 1'b1, '0);
    send_event(KIND_READ_LONG, base + 20000, '0, 1'b0, '0);
    send_event(KIND_READ_STAMP, base, '0, 1'b0, 5'd4);
    send_event(KIND_READ_STAMP, base, '0, 1'b0, 5'd5);
    send_event(KIND_READ_STAMP, base, '0, 1'b0, 5'd31);
    send_event(KIND_PULSE, base + 12000, '0, 1'b1, '0);
    // two stamps are recent, the third sits exactly at the window
    send_event(KIND_DELETE, base + 14000, '0, 1'b0, '0);
    send_event(KIND_DECREMENT, base, '1, 1'b0, '0);
    send_event(KIND_DELETE, base + 14000, '0, 1'b0, '0);
    send_event(KIND_PERIOD, base, '0, 1'b0, '0);
    send_event(KIND_READ_LONG, base + 20000, '0, 1'b0, '0);
    send_event(KIND_CLEAR_HIST, base, '0, 1'b0, '0);
    send_event(KIND_READ_STAMP, base, '0, 1'b0, '0);
    send_event(KIND_CLEAR, base, '0, 1'b0, '0);
    send_event(KIND_CLEAR, base, '0, 1'b1, '0);
    // zero-valued stamp is deleted like any other; count already zero
    send_event(KIND_PULSE, '0, '0, 1'b0, '0);
    send_event(KIND_DELETE, 32'd100, '0, 1'b0, '0);
    directed_sent = sent;

    for (int p = 0; p < PASSES; p++) begin
      case (p)
        0: begin pass_mode = 1'b0; pass_window = WINDOW_RESET; end
        1: begin pass_mode = 1'b0; pass_window = '0; end
        2: begin pass_mode = 1'b0; pass_window = '1; end
        3: begin pass_mode = 1'b1; pass_window = $urandom; end
        4: begin pass_mode = 1'b0; pass_window = 32'd2000; end
        5: begin pass_mode = 1'b0; pass_window = $urandom_range(100000, 1); end
        6: begin pass_mode = 1'b1; pass_window = '1; end
        default: begin pass_mode = 1'b0; pass_window = $urandom; end
      endcase
      if (p != 0) begin
        settle();
        write_reg(REG_MODE, DATA_W'(pass_mode));
        write_reg(REG_WINDOW, pass_window);
      end
      if (p == 2) hold_go <= ~hold_go;
      if (p == 5) burst <= 1'b1;
      if (p == 6) burst <= 1'b0;
      // count left at all-ones minus one by the previous pass: step it through the wrap
      if (p == 4) begin
        send_event(KIND_PULSE, wall_ms, '0, 1'b1, '0);
        send_event(KIND_PULSE, wall_ms, '0, 1'b1, '0);
      end
      repeat (EVENTS_PER_PASS) random_event();
      if (p == 3) send_event(KIND_SET_USAGE, wall_ms, '1, 1'b0, '0);
    end

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("%0d events sent (%0d directed), %0d results compared",
             sent, directed_sent, results_seen);
    $display("covered both modes, windows of zero, default, all-ones and random, a long hold");
    if (fail_count == 0 && waiting == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches, %0d results still outstanding", fail_count, waiting);
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/core/pcch_pkg.sv
rtl/core/pcch_if.sv
rtl/core/pcch_ctrl.sv
rtl/core/pcch_dp.sv
rtl/core/pulse_cycle_counter_with_history.sv
rtl/core/pcch_checker.sv
sim/meter_event_checker.sv
sim/testbench.sv
